// File: design/bli2d_pkg.sv
package bli2d_pkg;

  localparam int COORD_W = 32;
  localparam int SPACE_W = 31;
  localparam int CNT_W   = 6;
  // cell index along one axis, enough for any point count the count register can hold
  localparam int IDX_W   = 6;
  localparam int OFF_W   = SPACE_W + IDX_W;
  // diff, clamp, one stage per index bit, final limit
  localparam int LOC_LAT = IDX_W + 3;
  localparam int NSUM_W  = 96;
  localparam int NUM_W   = 94;
  localparam int DEN_W   = 2 * SPACE_W;
  localparam int QUO_W   = 32;
  // sign, one stage per quotient bit, sign restore
  localparam int DIV_LAT = QUO_W + 2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_ORG_X = 3'd2;
  localparam logic [2:0] REG_ORG_Y = 3'd3;
  localparam logic [2:0] REG_SPC_X = 3'd4;
  localparam logic [2:0] REG_SPC_Y = 3'd5;

  // request operations
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

endpackage

// File: design/bli2d_locate.sv
module bli2d_locate (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [bli2d_pkg::COORD_W-1:0]   coord,
  input  logic signed [bli2d_pkg::COORD_W-1:0]   origin,
  input  logic        [bli2d_pkg::SPACE_W-1:0]   spacing,
  input  logic        [bli2d_pkg::OFF_W-1:0]     last,
  input  logic        [bli2d_pkg::IDX_W-1:0]     idx_max,
  output logic        [bli2d_pkg::IDX_W-1:0]     idx,
  output logic        [bli2d_pkg::SPACE_W-1:0]   frac
);

  localparam int CW = bli2d_pkg::COORD_W;
  localparam int OW = bli2d_pkg::OFF_W;
  localparam int IW = bli2d_pkg::IDX_W;
  localparam int SW = bli2d_pkg::SPACE_W;

  logic [CW:0]   diff_r;
  logic [OW-1:0] off_nxt;
  logic [OW-1:0] rem_r [IW+1];
  logic [IW-1:0] quo_r [IW+1];
  logic [IW-1:0] idx_r;
  logic [SW-1:0] frac_r;

  always_comb begin
    if (diff_r[CW]) begin
      off_nxt = '0;
    end else if (OW'(diff_r[CW-1:0]) > last) begin
      off_nxt = last;
    end else begin
      off_nxt = OW'(diff_r[CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r   <= {coord[CW-1], coord} - {origin[CW-1], origin};
      rem_r[0] <= off_nxt;
      quo_r[0] <= '0;
      // restoring division, one quotient bit per stage, msb first
      for (int k = 0; k < IW; k++) begin
        if (rem_r[k] >= (OW'(spacing) << (IW - 1 - k))) begin
          rem_r[k+1] <= rem_r[k] - (OW'(spacing) << (IW - 1 - k));
          quo_r[k+1] <= {quo_r[k][IW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem_r[k];
          quo_r[k+1] <= {quo_r[k][IW-2:0], 1'b0};
        end
      end
      // on the last point: use the last cell with a full step
      if (quo_r[IW] > idx_max) begin
        idx_r  <= idx_max;
        frac_r <= spacing;
      end else begin
        idx_r  <= quo_r[IW];
        frac_r <= rem_r[IW][SW-1:0];
      end
    end
  end

  assign idx  = idx_r;
  assign frac = frac_r;

endmodule

// File: design/bli2d_div.sv
module bli2d_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic        [bli2d_pkg::NSUM_W-1:0]  num,
  input  logic        [bli2d_pkg::DEN_W-1:0]   den,
  output logic signed [bli2d_pkg::QUO_W-1:0]   quo
);

  localparam int NW = bli2d_pkg::NUM_W;
  localparam int SW = bli2d_pkg::NSUM_W;
  localparam int QW = bli2d_pkg::QUO_W;

  logic [SW-1:0] mag_nxt;
  logic [NW-1:0] rem_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          neg_r [QW+1];
  logic [QW-1:0] quo_r;

  assign mag_nxt = num[SW-1] ? (~num + SW'(1)) : num;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= num[SW-1];
      rem_r[0] <= mag_nxt[NW-1:0];
      q_r[0]   <= '0;
      for (int k = 0; k < QW; k++) begin
        neg_r[k+1] <= neg_r[k];
        if (rem_r[k] >= (NW'(den) << (QW - 1 - k))) begin
          rem_r[k+1] <= rem_r[k] - (NW'(den) << (QW - 1 - k));
          q_r[k+1]   <= {q_r[k][QW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= {q_r[k][QW-2:0], 1'b0};
        end
      end
      // truncation toward zero: divide the magnitude, then restore the sign
      quo_r <= neg_r[QW] ? (~q_r[QW] + QW'(1)) : q_r[QW];
    end
  end

  assign quo = quo_r;

endmodule

// File: design/bilinear_lut_interpolation_2d_unit.sv
// Bilinear lookup table, signed Q16.16. A request with op 0 stores one grid entry; a
// request with op 1 clamps (coord_x, coord_y) onto the grid set by origin and spacing,
// reads the four surrounding entries and returns their bilinear blend, the final
// division truncated toward zero. The unit is fully pipelined: one request per clock
// unless stalled, results returning in request order; writes take effect in order with
// lookups. The depth is set by the serial dividers, six stages for the cell index on
// each axis and 32 stages for the final quotient. The table sits in four banks split
// by row and column parity, so the four neighbors are read in the same cycle. A
// stalled result holds the whole pipeline. Entries not yet written read as garbage;
// the user must change configuration only while idle; the block does not enforce it.
module bilinear_lut_interpolation_2d_unit #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [4:0]         in_entry_row,
  input  logic [4:0]         in_entry_col,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_interpolated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W   = bli2d_pkg::CNT_W;
  localparam int SW      = bli2d_pkg::SPACE_W;
  localparam int OW      = bli2d_pkg::OFF_W;
  localparam int IW      = bli2d_pkg::IDX_W;
  localparam int POS_W   = 5;
  localparam int BANK_R  = (MAX_ROWS + 1) / 2;
  localparam int BANK_C  = (MAX_COLS + 1) / 2;
  localparam int BANK_D  = BANK_R * BANK_C;
  localparam int AW      = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  localparam int ST_LOC  = bli2d_pkg::LOC_LAT;
  localparam int ST_P5   = ST_LOC + 7;
  localparam int ST_OUT  = ST_P5 + bli2d_pkg::DIV_LAT;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [31:0]      value;
  } wr_item_t;

  // configuration
  logic [CNT_W-1:0]  rows_r, cols_r;
  logic signed [31:0] org_x_r, org_y_r;
  logic [SW-1:0]     spc_x_r, spc_y_r;
  logic              cfg_wr;

  logic [SW-1:0]     sx_eff, sy_eff;
  logic [CNT_W-1:0]  rows_eff, cols_eff;
  logic [SW-1:0]     sx_r, sy_r;
  logic [OW-1:0]     last_x_r, last_y_r;
  logic [IW-1:0]     xmax_r, ymax_r;
  logic [bli2d_pkg::DEN_W-1:0] den_r;

  // pipeline control
  logic              en;
  logic [ST_OUT:0]   lk_r;
  logic [ST_LOC:0]   wr_r;
  logic              wen_r;

  // payload
  logic signed [31:0] cx_r, cy_r;
  wr_item_t          wd_r [ST_LOC+1];
  logic [IW-1:0]     row_idx, col_idx;
  logic [SW-1:0]     frac_x, frac_y;

  logic [AW-1:0]     raddr_nxt [4];
  logic [AW-1:0]     raddr_r [4];
  logic [AW-1:0]     wad_r;
  logic [1:0]        wbk_r;
  logic [31:0]       wval_r;
  logic [1:0]        par_a_r, par_m_r;
  logic [SW-1:0]     wx0_a_r, wx1_a_r, wy0_a_r, wy1_a_r;
  logic [SW-1:0]     wx0_m_r, wx1_m_r, wy0_m_r, wy1_m_r;
  logic [31:0]       bank_rd [4];

  logic signed [31:0] f11, f21, f12, f22;
  logic signed [31:0] wx0_s, wx1_s;
  logic signed [63:0] p11_r, p21_r, p12_r, p22_r;
  logic [SW-1:0]     wy0_1_r, wy1_1_r, wy0_2_r, wy1_2_r;
  logic signed [63:0] a_r, b_r;
  logic signed [31:0] a_hi, b_hi, wy0_s, wy1_s;
  logic signed [63:0] ahw_r, bhw_r;
  logic [63:0]       alw_r, blw_r;
  logic signed [63:0] hi_r;
  logic [63:0]       lo_r;
  logic [bli2d_pkg::NSUM_W-1:0] n_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= CNT_W'(2);
      cols_r  <= CNT_W'(2);
      org_x_r <= '0;
      org_y_r <= '0;
      spc_x_r <= SW'(65536);
      spc_y_r <= SW'(65536);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        bli2d_pkg::REG_ROWS:  rows_r  <= pwdata[CNT_W-1:0];
        bli2d_pkg::REG_COLS:  cols_r  <= pwdata[CNT_W-1:0];
        bli2d_pkg::REG_ORG_X: org_x_r <= pwdata;
        bli2d_pkg::REG_ORG_Y: org_y_r <= pwdata;
        bli2d_pkg::REG_SPC_X: spc_x_r <= pwdata[SW-1:0];
        bli2d_pkg::REG_SPC_Y: spc_y_r <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      bli2d_pkg::REG_ROWS:  prdata = 32'(rows_r);
      bli2d_pkg::REG_COLS:  prdata = 32'(cols_r);
      bli2d_pkg::REG_ORG_X: prdata = org_x_r;
      bli2d_pkg::REG_ORG_Y: prdata = org_y_r;
      bli2d_pkg::REG_SPC_X: prdata = 32'(spc_x_r);
      bli2d_pkg::REG_SPC_Y: prdata = 32'(spc_y_r);
      default:              prdata = '0;
    endcase
  end

  // effective settings: zero spacing acts as one, point counts held between 2 and the store size
  always_comb begin
    sx_eff = (spc_x_r == '0) ? SW'(1) : spc_x_r;
    sy_eff = (spc_y_r == '0) ? SW'(1) : spc_y_r;
    if (rows_r < CNT_W'(2)) begin
      rows_eff = CNT_W'(2);
    end else if (32'(rows_r) > MAX_ROWS) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_r;
    end
    if (cols_r < CNT_W'(2)) begin
      cols_eff = CNT_W'(2);
    end else if (32'(cols_r) > MAX_COLS) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = cols_r;
    end
  end

  always_ff @(posedge clk) begin
    sx_r     <= sx_eff;
    sy_r     <= sy_eff;
    last_x_r <= OW'(sx_eff) * OW'(rows_eff - CNT_W'(1));
    last_y_r <= OW'(sy_eff) * OW'(cols_eff - CNT_W'(1));
    xmax_r   <= IW'(rows_eff - CNT_W'(2));
    ymax_r   <= IW'(cols_eff - CNT_W'(2));
    den_r    <= bli2d_pkg::DEN_W'(sx_eff) * bli2d_pkg::DEN_W'(sy_eff);
  end

  // ---------------- pipeline control ----------------
  assign out_valid = lk_r[ST_OUT];
  assign en        = !(lk_r[ST_OUT] && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_r  <= '0;
      wr_r  <= '0;
      wen_r <= 1'b0;
    end else if (en) begin
      lk_r  <= {lk_r[ST_OUT-1:0], in_valid && (in_op == bli2d_pkg::OP_LOOKUP)};
      wr_r  <= {wr_r[ST_LOC-1:0], in_valid && (in_op == bli2d_pkg::OP_WRITE)};
      // writes outside the store are dropped
      wen_r <= wr_r[ST_LOC] && (32'(wd_r[ST_LOC].row) < MAX_ROWS)
               && (32'(wd_r[ST_LOC].col) < MAX_COLS);
    end
  end

  // ---------------- request register and write-field delay ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r           <= in_coord_x;
      cy_r           <= in_coord_y;
      wd_r[0].row    <= in_entry_row;
      wd_r[0].col    <= in_entry_col;
      wd_r[0].value  <= in_entry_value;
      for (int k = 0; k < ST_LOC; k++) begin
        wd_r[k+1] <= wd_r[k];
      end
    end
  end

  // ---------------- cell location ----------------
  bli2d_locate u_loc_x (
    .clk     (clk),
    .en      (en),
    .coord   (cx_r),
    .origin  (org_x_r),
    .spacing (sx_r),
    .last    (last_x_r),
    .idx_max (xmax_r),
    .idx     (row_idx),
    .frac    (frac_x)
  );

  bli2d_locate u_loc_y (
    .clk     (clk),
    .en      (en),
    .coord   (cy_r),
    .origin  (org_y_r),
    .spacing (sy_r),
    .last    (last_y_r),
    .idx_max (ymax_r),
    .idx     (col_idx),
    .frac    (frac_y)
  );

  // ---------------- bank addressing ----------------
  // bank {row parity, col parity}; each neighbor lands in a different bank
  always_comb begin
    logic [IW:0] rr;
    logic [IW:0] cc;
    logic [1:0]  bk;
    for (int b = 0; b < 4; b++) begin
      bk = 2'(b);
      rr = {1'b0, row_idx} + (IW+1)'(row_idx[0] != bk[1]);
      cc = {1'b0, col_idx} + (IW+1)'(col_idx[0] != bk[0]);
      raddr_nxt[b] = AW'(32'(rr[IW:1]) * BANK_C + 32'(cc[IW:1]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        raddr_r[b] <= raddr_nxt[b];
      end
      wad_r   <= AW'(32'(wd_r[ST_LOC].row[POS_W-1:1]) * BANK_C
                     + 32'(wd_r[ST_LOC].col[POS_W-1:1]));
      wbk_r   <= {wd_r[ST_LOC].row[0], wd_r[ST_LOC].col[0]};
      wval_r  <= wd_r[ST_LOC].value;
      par_a_r <= {row_idx[0], col_idx[0]};
      wx0_a_r <= sx_r - frac_x;
      wx1_a_r <= frac_x;
      wy0_a_r <= sy_r - frac_y;
      wy1_a_r <= frac_y;
    end
  end

  // ---------------- table banks ----------------
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] mem [BANK_D];
    logic [31:0] rd_r;

    always_ff @(posedge clk) begin
      if (en) begin
        if (wen_r && wbk_r == 2'(b)) begin
          mem[wad_r] <= wval_r;
        end
        rd_r <= mem[raddr_r[b]];
      end
    end

    assign bank_rd[b] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par_m_r <= par_a_r;
      wx0_m_r <= wx0_a_r;
      wx1_m_r <= wx1_a_r;
      wy0_m_r <= wy0_a_r;
      wy1_m_r <= wy1_a_r;
    end
  end

  // ---------------- blend along x ----------------
  assign f11   = bank_rd[{par_m_r[1], par_m_r[0]}];
  assign f21   = bank_rd[{~par_m_r[1], par_m_r[0]}];
  assign f12   = bank_rd[{par_m_r[1], ~par_m_r[0]}];
  assign f22   = bank_rd[{~par_m_r[1], ~par_m_r[0]}];
  assign wx0_s = {1'b0, wx0_m_r};
  assign wx1_s = {1'b0, wx1_m_r};

  always_ff @(posedge clk) begin
    if (en) begin
      p11_r   <= f11 * wx0_s;
      p21_r   <= f21 * wx1_s;
      p12_r   <= f12 * wx0_s;
      p22_r   <= f22 * wx1_s;
      wy0_1_r <= wy0_m_r;
      wy1_1_r <= wy1_m_r;

      a_r     <= p11_r + p21_r;
      b_r     <= p12_r + p22_r;
      wy0_2_r <= wy0_1_r;
      wy1_2_r <= wy1_1_r;
    end
  end

  // ---------------- blend along y, split into 32-bit halves ----------------
  assign a_hi  = a_r[63:32];
  assign b_hi  = b_r[63:32];
  assign wy0_s = {1'b0, wy0_2_r};
  assign wy1_s = {1'b0, wy1_2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ahw_r <= a_hi * wy0_s;
      bhw_r <= b_hi * wy1_s;
      alw_r <= a_r[31:0] * 64'(wy0_2_r);
      blw_r <= b_r[31:0] * 64'(wy1_2_r);

      hi_r  <= ahw_r + bhw_r;
      lo_r  <= alw_r + blw_r;

      n_r   <= {hi_r, 32'b0} + {32'b0, lo_r};
    end
  end

  // ---------------- divide by spacing_x * spacing_y ----------------
  bli2d_div u_div (
    .clk (clk),
    .en  (en),
    .num (n_r),
    .den (den_r),
    .quo (out_interpolated)
  );

endmodule
